@@ rtl/teab_pkg.sv @@
// Shared constants, codes, types and helper functions of the edge adjacency builder.
package teab_pkg;

	localparam int MAX_TRIANGLES = 256;
	localparam int MAX_EDGES     = 768;
	localparam int VERTEX_BITS   = 16;

	localparam int TRI_ADDR_BITS = 8;
	localparam int TRI_CNT_BITS  = 9;
	localparam int EDGE_BITS     = 10;
	localparam int REF_BITS      = 9;
	localparam int CNT_BITS      = 12;
	localparam int OP_BITS       = 3;
	localparam int STATUS_BITS   = 2;
	localparam int FOUND_BITS    = 3;
	localparam int VTOTAL_BITS   = 17;

	localparam logic [EDGE_BITS-1:0] EDGE_NONE = 10'd1023;
	localparam logic [REF_BITS-1:0]  TRI_NONE  = 9'd256;

	localparam int TRI_ROW_BITS  = 3 * VERTEX_BITS;
	localparam int EDGE_ROW_BITS = 3 * EDGE_BITS;
	localparam int PAR_ROW_BITS  = 2 * REF_BITS;

	typedef enum logic [OP_BITS-1:0] {
		OP_ADD   = 3'd0,
		OP_CLOSE = 3'd1,
		OP_RDTRI = 3'd2,
		OP_RDEDG = 3'd3,
		OP_CLEAR = 3'd4
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_RANGE  = 2'd2,
		ST_PHASE  = 2'd3
	} status_t;

	typedef logic [2:0][VERTEX_BITS-1:0] tri_vtx_t;
	typedef logic [2:0][EDGE_BITS-1:0]   tri_edge_t;
	typedef logic [2:0][REF_BITS-1:0]    tri_ref_t;

	// Local edge (l1, l2) pair match mask, bit l1*3+l2
	function automatic logic [8:0] match_mask(input tri_vtx_t a, input tri_vtx_t b);
		logic [1:0] lo [3];
		logic [1:0] hi [3];
		logic [8:0] m;
		lo = '{2'd0, 2'd0, 2'd1};
		hi = '{2'd1, 2'd2, 2'd2};
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				m[i*3+j] = (a[lo[i]] == b[lo[j]] && a[hi[i]] == b[hi[j]]) ||
					(a[lo[i]] == b[hi[j]] && a[hi[i]] == b[lo[j]]);
			end
		end
		return m;
	endfunction

	// Local edge of the new triangle for a match bit
	function automatic logic [1:0] pair_l1(input logic [3:0] b);
		logic [1:0] r;
		case (b)
			4'd0, 4'd1, 4'd2: r = 2'd0;
			4'd3, 4'd4, 4'd5: r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

	// Local edge of the earlier triangle for a match bit
	function automatic logic [1:0] pair_l2(input logic [3:0] b);
		logic [1:0] r;
		case (b)
			4'd0, 4'd3, 4'd6: r = 2'd0;
			4'd1, 4'd4, 4'd7: r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/teab_req_if.sv @@
// Request channel: operation word with vertices and index.
interface teab_req_if;
	logic                                valid;
	logic                                ready;
	logic [teab_pkg::OP_BITS-1:0]        op;
	logic [teab_pkg::VERTEX_BITS-1:0]    vertex_a;
	logic [teab_pkg::VERTEX_BITS-1:0]    vertex_b;
	logic [teab_pkg::VERTEX_BITS-1:0]    vertex_c;
	logic [teab_pkg::EDGE_BITS-1:0]      index;

	modport source(output valid, op, vertex_a, vertex_b, vertex_c, index, input ready);
	modport sink(input valid, op, vertex_a, vertex_b, vertex_c, index, output ready);
endinterface

@@ rtl/teab_rsp_if.sv @@
// Response channel: status, edge ids, neighbours and totals.
interface teab_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [teab_pkg::STATUS_BITS-1:0]    status;
	logic [teab_pkg::TRI_ADDR_BITS-1:0]  tri_index;
	logic [teab_pkg::FOUND_BITS-1:0]     found_count;
	logic [teab_pkg::EDGE_BITS-1:0]      edge_id_0;
	logic [teab_pkg::EDGE_BITS-1:0]      edge_id_1;
	logic [teab_pkg::EDGE_BITS-1:0]      edge_id_2;
	logic [teab_pkg::REF_BITS-1:0]       tri_ref_0;
	logic [teab_pkg::REF_BITS-1:0]       tri_ref_1;
	logic [teab_pkg::REF_BITS-1:0]       tri_ref_2;
	logic [teab_pkg::EDGE_BITS-1:0]      edge_total;
	logic [teab_pkg::VTOTAL_BITS-1:0]    vertex_total;

	modport source(output valid, status, tri_index, found_count, edge_id_0, edge_id_1,
		edge_id_2, tri_ref_0, tri_ref_1, tri_ref_2, edge_total, vertex_total, input ready);
	modport sink(input valid, status, tri_index, found_count, edge_id_0, edge_id_1,
		edge_id_2, tri_ref_0, tri_ref_1, tri_ref_2, edge_total, vertex_total, output ready);
endinterface

@@ rtl/triangle_edge_adjacency_builder_unit.sv @@
// Each operation runs from the accepting cycle to the one that loads the output word,
// one request at a time; a new one may be accepted while the last output word is held.
// Errors caught at accept go straight to the output. Add and close run a counting sweep
// (one triangle per cycle), then an update sweep (S_RD, S_MATCH, S_ASSIGN handing out
// new edges); a held output word stalls only the last step.
// Reset clears counters, closed flag and handshake state; RAM contents stay undefined.
module triangle_edge_adjacency_builder_unit (
	input  logic       clk,
	input  logic       arst_n,
	teab_req_if.sink   req,
	teab_rsp_if.source rsp
);
	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_CNT    = 13'b0000000000010,
		S_CHK    = 13'b0000000000100,
		S_RD     = 13'b0000000001000,
		S_MATCH  = 13'b0000000010000,
		S_ASSIGN = 13'b0000000100000,
		S_TRD    = 13'b0000001000000,
		S_TROW   = 13'b0000010000000,
		S_TSLOT  = 13'b0000100000000,
		S_TNB    = 13'b0001000000000,
		S_ERD    = 13'b0010000000000,
		S_EDAT   = 13'b0100000000000,
		S_RESP   = 13'b1000000000000
	} state_t;

	state_t                                 state_q;
	teab_pkg::op_t                          op_q;
	teab_pkg::tri_vtx_t                     vtx_q;
	logic [teab_pkg::EDGE_BITS-1:0]         idx_q;
	logic [teab_pkg::TRI_CNT_BITS-1:0]      tri_cnt_q;
	logic [teab_pkg::EDGE_BITS-1:0]         edge_cnt_q;
	logic [teab_pkg::VERTEX_BITS-1:0]       maxv_q;
	logic                                   closed_q;
	logic [teab_pkg::TRI_CNT_BITS-1:0]      ptr_q;
	logic                                   rv_q;
	logic [teab_pkg::CNT_BITS-1:0]          cnt_q;
	logic [8:0]                             mask_q;
	teab_pkg::tri_edge_t                    row_q;
	teab_pkg::tri_edge_t                    nslot_q;
	teab_pkg::tri_ref_t                     nnb_q;
	teab_pkg::status_t                      res_status_q;
	logic [teab_pkg::TRI_ADDR_BITS-1:0]     res_tri_q;
	logic [teab_pkg::FOUND_BITS-1:0]        res_found_q;
	teab_pkg::tri_edge_t                    res_e_q;
	teab_pkg::tri_ref_t                     res_r_q;
	logic                                   ovld_q;
	teab_pkg::status_t                      o_status_q;
	logic [teab_pkg::TRI_ADDR_BITS-1:0]     o_tri_q;
	logic [teab_pkg::FOUND_BITS-1:0]        o_found_q;
	teab_pkg::tri_edge_t                    o_e_q;
	teab_pkg::tri_ref_t                     o_r_q;
	logic [teab_pkg::EDGE_BITS-1:0]         o_etot_q;
	logic [teab_pkg::VTOTAL_BITS-1:0]       o_vtot_q;

	logic [teab_pkg::TRI_ADDR_BITS-1:0]     tri_raddr;
	logic [teab_pkg::TRI_ROW_BITS-1:0]      tv_rdata;
	logic [teab_pkg::EDGE_ROW_BITS-1:0]     te_rdata;
	logic                                   tv_we;
	logic                                   te_we;
	logic [teab_pkg::EDGE_ROW_BITS-1:0]     te_wdata;
	logic                                   ep_we;
	logic [teab_pkg::PAR_ROW_BITS-1:0]      ep_wdata;
	logic [teab_pkg::EDGE_BITS-1:0]         ep_raddr;
	logic [teab_pkg::PAR_ROW_BITS-1:0]      ep_rdata;
	teab_pkg::tri_edge_t                    te_row;
	logic [8:0]                             new_mask;
	logic [3:0]                             low_bit;
	logic                                   sweep_end;
	logic                                   is_add;
	logic [1:0]                             slot;
	logic [teab_pkg::REF_BITS-1:0]          par0;
	logic [teab_pkg::REF_BITS-1:0]          par1;
	logic [teab_pkg::REF_BITS-1:0]          nb;
	logic [teab_pkg::EDGE_BITS+2:0]         need;
	logic [teab_pkg::VERTEX_BITS-1:0]       maxv_new;

	function automatic logic [teab_pkg::CNT_BITS-1:0] CNT_ADD(input logic [8:0] m);
		return teab_pkg::CNT_BITS'($countones(m));
	endfunction

	assign te_row    = teab_pkg::tri_edge_t'(te_rdata);
	assign is_add    = (op_q == teab_pkg::OP_ADD);
	assign sweep_end = (ptr_q == tri_cnt_q);
	assign slot      = ptr_q[1:0];
	assign par0      = ep_rdata[teab_pkg::PAR_ROW_BITS-1:teab_pkg::REF_BITS];
	assign par1      = ep_rdata[teab_pkg::REF_BITS-1:0];
	assign need      = {3'b000, edge_cnt_q} + {1'b0, cnt_q};

	// Match mask for the row just read: shared edges on add, empty slots on close
	always_comb begin
		if (is_add) begin
			new_mask = teab_pkg::match_mask(vtx_q, teab_pkg::tri_vtx_t'(tv_rdata));
		end else begin
			new_mask = 9'd0;
			for (int k = 0; k < 3; k++) begin
				new_mask[k] = (te_row[k] == teab_pkg::EDGE_NONE);
			end
		end
	end

	// Pick the lowest pending match
	always_comb begin
		low_bit = 4'd0;
		for (int k = 8; k >= 0; k--) begin
			if (mask_q[k]) begin
				low_bit = 4'(k);
			end
		end
	end

	// Neighbour of the triangle being read across the edge just fetched
	always_comb begin
		if (par0 == idx_q[teab_pkg::REF_BITS-1:0]) begin
			nb = par1;
		end else if (par1 == idx_q[teab_pkg::REF_BITS-1:0]) begin
			nb = par0;
		end else begin
			nb = teab_pkg::TRI_NONE;
		end
	end

	// Running maximum vertex including the added triangle
	always_comb begin
		maxv_new = maxv_q;
		for (int k = 0; k < 3; k++) begin
			if (vtx_q[k] > maxv_new) begin
				maxv_new = vtx_q[k];
			end
		end
	end

	// RAM addressing and write strobes
	always_comb begin
		tri_raddr = (state_q == S_TRD) ? idx_q[teab_pkg::TRI_ADDR_BITS-1:0]
			: ptr_q[teab_pkg::TRI_ADDR_BITS-1:0];
		ep_raddr  = (state_q == S_ERD) ? idx_q : row_q[slot];
		tv_we     = (state_q == S_RD) && sweep_end && is_add;
		te_we     = ((state_q == S_ASSIGN) && (mask_q == 9'd0)) || tv_we;
		te_wdata  = tv_we ? nslot_q : row_q;
		ep_we     = (state_q == S_ASSIGN) && (mask_q != 9'd0);
		ep_wdata  = is_add ? {tri_cnt_q, ptr_q} : {ptr_q, teab_pkg::TRI_NONE};
	end

	teab_ram #(.WIDTH(teab_pkg::TRI_ROW_BITS), .DEPTH(teab_pkg::MAX_TRIANGLES)) u_vtx_ram (
		.clk   (clk),
		.we    (tv_we),
		.waddr (ptr_q[teab_pkg::TRI_ADDR_BITS-1:0]),
		.wdata (vtx_q),
		.raddr (tri_raddr),
		.rdata (tv_rdata)
	);

	teab_ram #(.WIDTH(teab_pkg::EDGE_ROW_BITS), .DEPTH(teab_pkg::MAX_TRIANGLES)) u_tedge_ram (
		.clk   (clk),
		.we    (te_we),
		.waddr (ptr_q[teab_pkg::TRI_ADDR_BITS-1:0]),
		.wdata (te_wdata),
		.raddr (tri_raddr),
		.rdata (te_rdata)
	);

	teab_ram #(.WIDTH(teab_pkg::PAR_ROW_BITS), .DEPTH(teab_pkg::MAX_EDGES)) u_par_ram (
		.clk   (clk),
		.we    (ep_we),
		.waddr (edge_cnt_q),
		.wdata (ep_wdata),
		.raddr (ep_raddr),
		.rdata (ep_rdata)
	);

	assign req.ready = (state_q == S_IDLE);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			tri_cnt_q  <= '0;
			edge_cnt_q <= '0;
			maxv_q     <= '0;
			closed_q   <= 1'b0;
			ovld_q     <= 1'b0;
			rv_q       <= 1'b0;
		end else begin
			// Drop the output word once taken, unless a new one loads now
			if (ovld_q && rsp.ready && (state_q != S_RESP)) begin
				ovld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q         <= teab_pkg::op_t'(req.op);
						vtx_q        <= {req.vertex_c, req.vertex_b, req.vertex_a};
						idx_q        <= req.index;
						ptr_q        <= '0;
						rv_q         <= 1'b0;
						cnt_q        <= '0;
						res_tri_q    <= '0;
						res_found_q  <= '0;
						res_e_q      <= {3{teab_pkg::EDGE_NONE}};
						res_r_q      <= {3{teab_pkg::TRI_NONE}};
						nslot_q      <= {3{teab_pkg::EDGE_NONE}};
						nnb_q        <= {3{teab_pkg::TRI_NONE}};
						case (teab_pkg::op_t'(req.op))
							teab_pkg::OP_ADD: begin
								if (closed_q) begin
									res_status_q <= teab_pkg::ST_PHASE;
									state_q      <= S_RESP;
								end else if (32'(tri_cnt_q) >= teab_pkg::MAX_TRIANGLES) begin
									res_status_q <= teab_pkg::ST_FULL;
									state_q      <= S_RESP;
								end else begin
									res_status_q <= teab_pkg::ST_OK;
									state_q      <= S_CNT;
								end
							end
							teab_pkg::OP_CLOSE: begin
								if (closed_q) begin
									res_status_q <= teab_pkg::ST_PHASE;
									state_q      <= S_RESP;
								end else begin
									res_status_q <= teab_pkg::ST_OK;
									state_q      <= S_CNT;
								end
							end
							teab_pkg::OP_RDTRI: begin
								if (req.index >= {1'b0, tri_cnt_q}) begin
									res_status_q <= teab_pkg::ST_RANGE;
									state_q      <= S_RESP;
								end else begin
									res_status_q <= teab_pkg::ST_OK;
									state_q      <= S_TRD;
								end
							end
							teab_pkg::OP_RDEDG: begin
								if (req.index >= edge_cnt_q) begin
									res_status_q <= teab_pkg::ST_RANGE;
									state_q      <= S_RESP;
								end else begin
									res_status_q <= teab_pkg::ST_OK;
									state_q      <= S_ERD;
								end
							end
							teab_pkg::OP_CLEAR: begin
								tri_cnt_q    <= '0;
								edge_cnt_q   <= '0;
								maxv_q       <= '0;
								closed_q     <= 1'b0;
								res_status_q <= teab_pkg::ST_OK;
								state_q      <= S_RESP;
							end
							default: begin
								res_status_q <= teab_pkg::ST_OK;
								state_q      <= S_RESP;
							end
						endcase
					end
				end
				// Count sweep: one row read per cycle, tallied in the cycle after its read
				S_CNT: begin
					rv_q <= !sweep_end;
					if (!sweep_end) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (rv_q) begin
						cnt_q <= cnt_q + CNT_ADD(new_mask);
					end
					if (sweep_end && !rv_q) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					ptr_q <= '0;
					if (32'(need) > teab_pkg::MAX_EDGES) begin
						res_status_q <= teab_pkg::ST_FULL;
						state_q      <= S_RESP;
					end else begin
						state_q <= S_RD;
					end
				end
				// Update sweep: issue row read or finish
				S_RD: begin
					if (sweep_end) begin
						if (is_add) begin
							tri_cnt_q   <= tri_cnt_q + 1'b1;
							maxv_q      <= maxv_new;
							res_tri_q   <= ptr_q[teab_pkg::TRI_ADDR_BITS-1:0];
							res_found_q <= (cnt_q > 12'd7) ? 3'd7 : cnt_q[2:0];
							res_e_q     <= nslot_q;
							res_r_q     <= nnb_q;
						end else begin
							closed_q <= 1'b1;
						end
						state_q <= S_RESP;
					end else begin
						state_q <= S_MATCH;
					end
				end
				S_MATCH: begin
					mask_q  <= new_mask;
					row_q   <= te_row;
					state_q <= S_ASSIGN;
				end
				// Hand out one new edge per cycle, then write the row back
				S_ASSIGN: begin
					if (mask_q == 9'd0) begin
						ptr_q   <= ptr_q + 1'b1;
						state_q <= S_RD;
					end else begin
						mask_q[low_bit] <= 1'b0;
						edge_cnt_q      <= edge_cnt_q + 1'b1;
						if (is_add) begin
							row_q[teab_pkg::pair_l2(low_bit)]   <= edge_cnt_q;
							nslot_q[teab_pkg::pair_l1(low_bit)] <= edge_cnt_q;
							nnb_q[teab_pkg::pair_l1(low_bit)]   <= ptr_q;
						end else begin
							row_q[low_bit[1:0]] <= edge_cnt_q;
						end
					end
				end
				S_TRD: begin
					state_q <= S_TROW;
				end
				S_TROW: begin
					row_q     <= te_row;
					res_e_q   <= te_row;
					res_tri_q <= idx_q[teab_pkg::TRI_ADDR_BITS-1:0];
					ptr_q     <= '0;
					state_q   <= S_TSLOT;
				end
				// Fetch parents of each used slot
				S_TSLOT: begin
					if (slot == 2'd3) begin
						state_q <= S_RESP;
					end else if (row_q[slot] == teab_pkg::EDGE_NONE) begin
						ptr_q <= ptr_q + 1'b1;
					end else begin
						state_q <= S_TNB;
					end
				end
				S_TNB: begin
					res_r_q[slot] <= nb;
					ptr_q         <= ptr_q + 1'b1;
					state_q       <= S_TSLOT;
				end
				S_ERD: begin
					state_q <= S_EDAT;
				end
				S_EDAT: begin
					res_tri_q  <= idx_q[teab_pkg::TRI_ADDR_BITS-1:0];
					res_r_q[0] <= par0;
					res_r_q[1] <= par1;
					state_q    <= S_RESP;
				end
				// Hand the word to the output register once it is free
				S_RESP: begin
					if (!ovld_q || rsp.ready) begin
						ovld_q     <= 1'b1;
						o_status_q <= res_status_q;
						o_tri_q    <= res_tri_q;
						o_found_q  <= res_found_q;
						o_e_q      <= res_e_q;
						o_r_q      <= res_r_q;
						o_etot_q   <= edge_cnt_q;
						o_vtot_q   <= {1'b0, maxv_q} + 17'd1;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = ovld_q;
	assign rsp.status       = o_status_q;
	assign rsp.tri_index    = o_tri_q;
	assign rsp.found_count  = o_found_q;
	assign rsp.edge_id_0    = o_e_q[0];
	assign rsp.edge_id_1    = o_e_q[1];
	assign rsp.edge_id_2    = o_e_q[2];
	assign rsp.tri_ref_0    = o_r_q[0];
	assign rsp.tri_ref_1    = o_r_q[1];
	assign rsp.tri_ref_2    = o_r_q[2];
	assign rsp.edge_total   = o_etot_q;
	assign rsp.vertex_total = o_vtot_q;
endmodule

@@ rtl/teab_ram.sv @@
// Generic single write port RAM with registered read.
module teab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
